[hw/rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue_top.
package spq_pkg;

    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 8;
    localparam int OCC_W        = 5;
    localparam int ENTRY_W      = VALUE_W + PRIO_W;
    localparam int CAPACITY_DEF = 16;

    // Operation codes on the opcode port
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Source of the entry RAM read address
    typedef enum logic {
        RD_ENTRY,   // first entry read at item accept: head for remove, tail for insert
        RD_NEXT     // next entry toward the head during the insert scan
    } rd_src_t;

    // Source of the entry RAM write data
    typedef enum logic {
        WR_ITEM,    // the captured new entry
        WR_MOVE     // the entry just read, moved one slot toward the tail
    } wr_src_t;

    // How the current item finishes
    typedef enum logic [2:0] {
        RES_NONE,
        RES_INSERTED,
        RES_OVERFLOW,
        RES_REMOVED,
        RES_UNDERFLOW
    } res_t;

    typedef struct packed {
        logic    load;      // capture the item fields
        logic    k_load;    // set scan index to the entry count
        logic    k_dec;     // step scan index toward the head
        rd_src_t rd_src;
        logic    wr_en;
        wr_src_t wr_src;
        res_t    finish;
    } spq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic k_one;        // scan index has reached the slot behind the head
        logic stop;         // entry read has priority >= the new one
    } spq_status_t;

endpackage

[hw/rtl/spq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write when enabled, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/spq_ctrl.sv]
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives spq_datapath through spq_cmd_t, reads spq_status_t.
module spq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 opcode,
    input  spq_pkg::spq_status_t status,
    output spq_pkg::spq_cmd_t    cmd,
    output logic                 busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD,
        S_REMOVE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = spq_pkg::RD_ENTRY;
        cmd.wr_src = spq_pkg::WR_ITEM;
        cmd.finish = spq_pkg::RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (opcode == spq_pkg::OP_INSERT)
                    begin
                        if (status.full)
                        begin
                            cmd.finish = spq_pkg::RES_OVERFLOW;
                        end
                        else
                        begin
                            cmd.k_load = 1'b1;
                            state_next = status.empty ? S_HEAD : S_SCAN;
                        end
                    end
                    else
                    begin
                        if (status.empty)
                        begin
                            cmd.finish = spq_pkg::RES_UNDERFLOW;
                        end
                        else
                        begin
                            state_next = S_REMOVE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_src = spq_pkg::RD_NEXT;
                cmd.wr_en  = 1'b1;
                if (status.stop)
                begin
                    // drop the new entry behind the one just read
                    cmd.wr_src = spq_pkg::WR_ITEM;
                    cmd.finish = spq_pkg::RES_INSERTED;
                    state_next = S_IDLE;
                end
                else
                begin
                    // move the entry one slot back and advance toward the head
                    cmd.wr_src = spq_pkg::WR_MOVE;
                    cmd.k_dec  = 1'b1;
                    if (status.k_one)
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = spq_pkg::WR_ITEM;
                cmd.finish = spq_pkg::RES_INSERTED;
                state_next = S_IDLE;
            end
            S_REMOVE:
            begin
                cmd.finish = spq_pkg::RES_REMOVED;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[hw/rtl/spq_datapath.sv]
// Datapath for the sorted priority queue: entry RAM as a circular buffer,
// count, head pointer, scan index and result registers.
// Depends on spq_pkg and spq_ram.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::spq_cmd_t                 cmd,
    output spq_pkg::spq_status_t              status,
    input  logic                              opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
    input  logic [spq_pkg::PRIO_W-1:0]        item_priority,
    output logic signed [spq_pkg::VALUE_W-1:0] out_value,
    output logic [spq_pkg::PRIO_W-1:0]        out_priority,
    output logic                              out_valid,
    output logic                              underflow,
    output logic                              overflow,
    output logic [spq_pkg::OCC_W-1:0]         occupancy,
    output logic                              done
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW    = spq_pkg::VALUE_W;
    localparam int PW    = spq_pkg::PRIO_W;
    localparam int EW    = spq_pkg::ENTRY_W;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic signed [VW-1:0]     item_value_reg;
    logic [PW-1:0]            item_priority_reg;

    logic signed [VW-1:0]     out_value_reg, out_value_next;
    logic [PW-1:0]            out_priority_reg, out_priority_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     underflow_reg, underflow_next;
    logic                     overflow_reg, overflow_next;
    logic                     done_reg, done_next;

    logic [CNT_W-1:0]         rd_logical;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;
    logic [EW-1:0]            rd_data;
    logic signed [VW-1:0]     rd_value;
    logic [PW-1:0]            rd_priority;

    // Map a position in priority order to a RAM slot, wrapping at CAPACITY
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [AW:0] sum;
        sum = (AW+1)'(head) + (AW+1)'(pos);
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_value    = $signed(rd_data[EW-1:PW]);
    assign rd_priority = rd_data[PW-1:0];

    // Status toward the controller
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(CAPACITY));
    assign status.k_one = (k_reg == CNT_W'(1));
    assign status.stop  = (rd_priority >= item_priority_reg);

    // Read address: head or tail at accept, then the next entry toward the head
    always_comb
    begin
        case (cmd.rd_src)
            spq_pkg::RD_NEXT:
            begin
                rd_logical = (k_reg >= CNT_W'(2)) ? (k_reg - CNT_W'(2)) : '0;
            end
            default:
            begin
                rd_logical = (opcode == spq_pkg::OP_REMOVE || count_reg == '0)
                             ? '0 : (count_reg - CNT_W'(1));
            end
        endcase
    end

    assign rd_addr = slot_of(head_reg, rd_logical);
    assign wr_addr = slot_of(head_reg, k_reg);
    assign wr_data = (cmd.wr_src == spq_pkg::WR_ITEM) ? {item_value_reg, item_priority_reg}
                                                      : rd_data;

    spq_ram #(
        .WIDTH  (EW),
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Scan index
    always_comb
    begin
        k_next = k_reg;
        if (cmd.k_load)
        begin
            k_next = count_reg;
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - CNT_W'(1);
        end
    end

    // Finish the item: update count and head, form the result
    always_comb
    begin
        count_next        = count_reg;
        head_next         = head_reg;
        out_value_next    = '0;
        out_priority_next = '0;
        out_valid_next    = 1'b0;
        underflow_next    = 1'b0;
        overflow_next     = 1'b0;
        done_next         = 1'b1;
        case (cmd.finish)
            spq_pkg::RES_INSERTED:
            begin
                count_next = count_reg + CNT_W'(1);
            end
            spq_pkg::RES_OVERFLOW:
            begin
                overflow_next = 1'b1;
            end
            spq_pkg::RES_REMOVED:
            begin
                out_value_next    = rd_value;
                out_priority_next = rd_priority;
                out_valid_next    = 1'b1;
                count_next        = count_reg - CNT_W'(1);
                head_next         = slot_of(head_reg, CNT_W'(1));
            end
            spq_pkg::RES_UNDERFLOW:
            begin
                underflow_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            k_reg         <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            underflow_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            k_reg         <= k_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            underflow_reg <= underflow_next;
            overflow_reg  <= overflow_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_value_reg    <= item_value;
            item_priority_reg <= item_priority;
        end
        out_value_reg    <= out_value_next;
        out_priority_reg <= out_priority_next;
    end

    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign out_valid    = out_valid_reg;
    assign underflow    = underflow_reg;
    assign overflow     = overflow_reg;
    assign occupancy    = spq_pkg::OCC_W'(count_reg);
    assign done         = done_reg;

endmodule

[hw/rtl/sorted_priority_queue_top.sv]
// Sorted priority queue, top level: ties controller and datapath together.
// Depends on spq_pkg, spq_ctrl, spq_datapath (which holds spq_ram).
//
// Holds up to CAPACITY (value, priority) entries in a RAM used as a circular
// buffer, ordered highest priority first, equal priorities in arrival order.
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, and it cannot be held
// off, so capture it on that cycle. A remove is accepted, then finishes in
// S_REMOVE once the head entry is read from the RAM. An insert moves each
// stored entry of lower priority one slot toward the tail in S_SCAN, then
// writes the new entry, in S_HEAD when it lands at the head; the insert
// scan moves one entry per cycle through the RAM's single write port. A
// refused insert or an empty remove finishes at accept. done rises in the
// cycle after the item finishes, and a new item may be started in that
// same cycle. occupancy gives the entry count after the item, kept to its
// low 5 bits. No clearing pass is needed after reset.
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
    input  logic [spq_pkg::PRIO_W-1:0]         item_priority,
    output logic                               done,
    output logic signed [spq_pkg::VALUE_W-1:0] out_value,
    output logic [spq_pkg::PRIO_W-1:0]         out_priority,
    output logic                               out_valid,
    output logic                               underflow,
    output logic                               overflow,
    output logic [spq_pkg::OCC_W-1:0]          occupancy
);

    localparam logic [spq_pkg::OCC_W-1:0] OCC_FULL = CAPACITY[spq_pkg::OCC_W-1:0];

    spq_pkg::spq_cmd_t    cmd;
    spq_pkg::spq_status_t status;

    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .out_valid     (out_valid),
        .underflow     (underflow),
        .overflow      (overflow),
        .occupancy     (occupancy),
        .done          (done)
    );

    // A result is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // At most one outcome flag per result, and only with done
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid || underflow || overflow) |->
            (done && $onehot0({out_valid, underflow, overflow})))
        else $error("bad outcome flags");

    // A refused insert leaves the queue full
    a_over_count: assert property (@(posedge clk) disable iff (!rst_n)
        overflow |-> (occupancy == OCC_FULL))
        else $error("occupancy does not match overflow");

    // An empty remove leaves the queue empty
    a_under_count: assert property (@(posedge clk) disable iff (!rst_n)
        underflow |-> (occupancy == '0))
        else $error("occupancy does not match underflow");

endmodule

[dv/sorted_priority_queue_top_tb.sv]
// Self-checking testbench for sorted_priority_queue_top: directed and random items.
// Depends on spq_pkg and the sorted_priority_queue_top RTL; reads no files.
// Keeps its own model of the queue contents and compares every done strobe to it.
module sorted_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QCAP        = spq_pkg::CAPACITY_DEF;
    localparam int ITEM_TARGET = 650;

    typedef struct {
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]         prio;
        logic                               valid;
        logic                               under;
        logic                               over;
        logic [spq_pkg::OCC_W-1:0]          occ;
    } queue_result_t;

    // Track queue contents and the results owed by the block
    class queue_tracker;
        logic signed [spq_pkg::VALUE_W-1:0] slot_value [QCAP];
        logic [spq_pkg::PRIO_W-1:0]         slot_prio [QCAP];
        int                                 held;
        int                                 errors;
        queue_result_t                      owed [$];

        function new();
            held   = 0;
            errors = 0;
        endfunction

        // Apply one accepted item to the model and queue up its result
        function void note_command(logic op, logic signed [spq_pkg::VALUE_W-1:0] val,
                                   logic [spq_pkg::PRIO_W-1:0] pri);
            queue_result_t r;
            int            pos;
            int            k;
            r.value = '0;
            r.prio  = '0;
            r.valid = 1'b0;
            r.under = 1'b0;
            r.over  = 1'b0;
            if (op == spq_pkg::OP_INSERT)
            begin
                if (held >= QCAP)
                begin
                    r.over = 1'b1;
                end
                else
                begin
                    // land behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < held && slot_prio[pos] >= pri)
                        pos++;
                    for (k = held; k > pos; k--)
                    begin
                        slot_value[k] = slot_value[k-1];
                        slot_prio[k]  = slot_prio[k-1];
                    end
                    slot_value[pos] = val;
                    slot_prio[pos]  = pri;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    r.under = 1'b1;
                end
                else
                begin
                    // pop the head and close the gap
                    r.value = slot_value[0];
                    r.prio  = slot_prio[0];
                    r.valid = 1'b1;
                    for (k = 1; k < held; k++)
                    begin
                        slot_value[k-1] = slot_value[k];
                        slot_prio[k-1]  = slot_prio[k];
                    end
                    held--;
                end
            end
            r.occ = spq_pkg::OCC_W'(held);
            owed.push_back(r);
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function int entries();
            return held;
        endfunction

        function void compare(string field, logic [spq_pkg::VALUE_W-1:0] want,
                              logic [spq_pkg::VALUE_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        // Match one strobed result against the oldest one owed
        function void check_response(queue_result_t got);
            queue_result_t want;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual value %0h",
                         $time, got.value);
                return;
            end
            want = owed.pop_front();
            compare("out_value", want.value, got.value);
            compare("out_priority", spq_pkg::VALUE_W'(want.prio),
                    spq_pkg::VALUE_W'(got.prio));
            compare("out_valid", spq_pkg::VALUE_W'(want.valid),
                    spq_pkg::VALUE_W'(got.valid));
            compare("underflow", spq_pkg::VALUE_W'(want.under),
                    spq_pkg::VALUE_W'(got.under));
            compare("overflow", spq_pkg::VALUE_W'(want.over),
                    spq_pkg::VALUE_W'(got.over));
            compare("occupancy", spq_pkg::VALUE_W'(want.occ),
                    spq_pkg::VALUE_W'(got.occ));
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               opcode;
    logic signed [spq_pkg::VALUE_W-1:0] item_value;
    logic [spq_pkg::PRIO_W-1:0]         item_priority;
    logic                               busy;
    logic                               done;
    logic signed [spq_pkg::VALUE_W-1:0] out_value;
    logic [spq_pkg::PRIO_W-1:0]         out_priority;
    logic                               out_valid;
    logic                               underflow;
    logic                               overflow;
    logic [spq_pkg::OCC_W-1:0]          occupancy;

    queue_tracker tracker = new();
    int           burst_left = 0;
    int           items_sent = 0;

    sorted_priority_queue_top #(
        .CAPACITY(QCAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .item_value   (item_value),
        .item_priority(item_priority),
        .done         (done),
        .out_value    (out_value),
        .out_priority (out_priority),
        .out_valid    (out_valid),
        .underflow    (underflow),
        .overflow     (overflow),
        .occupancy    (occupancy)
    );

    // Run the clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Capture every strobed result
    always @(posedge clk)
    begin
        queue_result_t got;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got.value = out_value;
            got.prio  = out_priority;
            got.valid = out_valid;
            got.under = underflow;
            got.over  = overflow;
            got.occ   = occupancy;
            tracker.check_response(got);
        end
    end

    // Drop start between bursts, then hold one item until the block takes it
    task automatic send_item(input logic op,
                             input logic signed [spq_pkg::VALUE_W-1:0] val,
                             input logic [spq_pkg::PRIO_W-1:0] pri);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 20);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start         <= 1'b1;
        opcode        <= op;
        item_value    <= val;
        item_priority <= pri;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_command(op, val, pri);
        items_sent++;
    endtask

    // Hold off until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Favor a few clustered priorities so ties are common
    function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(8'h80 + $urandom_range(0, 2));
            3: return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic pick_op(int remove_pct);
        return ($urandom_range(1, 100) <= remove_pct) ? spq_pkg::OP_REMOVE
                                                      : spq_pkg::OP_INSERT;
    endfunction

    // Stimulus
    initial
    begin
        int  phase;
        int  extra;
        int  n;
        bit  paused;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        opcode        <= spq_pkg::OP_INSERT;
        item_value    <= '0;
        item_priority <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty remove, extreme values and priorities, ties, head insert
        send_item(spq_pkg::OP_REMOVE, 32'h1234_5678, 8'hff);
        send_item(spq_pkg::OP_INSERT, 32'h7fff_ffff, 8'd0);
        send_item(spq_pkg::OP_INSERT, 32'h8000_0000, 8'd255);
        send_item(spq_pkg::OP_INSERT, 32'h0000_0000, 8'd255);
        send_item(spq_pkg::OP_INSERT, 32'hffff_ffff, 8'd128);
        send_item(spq_pkg::OP_INSERT, 32'h0000_0001, 8'd0);
        send_item(spq_pkg::OP_INSERT, 32'h5555_aaaa, 8'd128);
        send_item(spq_pkg::OP_INSERT, 32'haaaa_5555, 8'd1);
        repeat (8) send_item(spq_pkg::OP_REMOVE, $urandom, 8'($urandom));
        send_item(spq_pkg::OP_REMOVE, 32'hffff_ffff, 8'd0);
        wait_drained();

        // Random phases: fill to overflow, drain to underflow, or mixed traffic
        paused = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            phase = $urandom_range(0, 3);
            case (phase)
                0:
                begin
                    while (tracker.entries() < QCAP)
                        send_item(pick_op(10), pick_value(), pick_prio());
                    extra = $urandom_range(1, 3);
                    repeat (extra) send_item(spq_pkg::OP_INSERT, pick_value(), pick_prio());
                end
                1:
                begin
                    while (tracker.entries() > 0)
                        send_item(pick_op(90), pick_value(), pick_prio());
                    extra = $urandom_range(1, 2);
                    repeat (extra) send_item(spq_pkg::OP_REMOVE, pick_value(), pick_prio());
                end
                default:
                begin
                    n = $urandom_range(10, 40);
                    repeat (n) send_item(pick_op(50), pick_value(), pick_prio());
                end
            endcase
            if (!paused || $urandom_range(0, 7) == 0)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // Let the last results arrive, then watch for strays
        wait_drained();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("sorted_priority_queue_top_tb: done, clean");
        else
            $display("sorted_priority_queue_top_tb: done, errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("sorted_priority_queue_top_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue_top.sv
dv/sorted_priority_queue_top_tb.sv
